// ----- src/poc_pkg.sv -----
// Shared types and constants for the precedence order checker.
// Holds the controller state encoding, command/status structs and field widths.
// No dependencies.
`default_nettype none

package poc_pkg;

   localparam int PAGE_W = 7;
   localparam int SUM_W  = 24;
   localparam logic [SUM_W-1:0] SUM_MAX = 24'hFFFFFF;

   localparam logic ACTION_RULE = 1'b0;
   localparam logic ACTION_PAGE = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_EXEC   = 4'b0100,
      ST_FINISH = 4'b1000
   } poc_state_type;

   typedef struct packed {
      logic capture;
      logic clear_write;
      logic exec;
      logic finish;
   } poc_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic needs_finish;
   } poc_status_type;

endpackage

`default_nettype wire

// ----- src/poc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module poc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                     clock,
   input  wire logic                                     we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/poc_ctrl.sv -----
// Controller state machine of the precedence order checker.
// Depends on poc_pkg for the state encoding and the command/status structs.
`default_nettype none

module poc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire poc_pkg::poc_status_type status,
   output poc_pkg::poc_cmd_type         cmd
);

   import poc_pkg::*;

   poc_state_type state_ff;
   poc_state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.needs_finish ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ----- src/poc_dp.sv -----
// Datapath of the precedence order checker: rule matrix, seen bitmap,
// sequence buffer, counters, saturating sum and result registers.
// Depends on poc_pkg and poc_ram.
`default_nettype none

module poc_dp #(
   parameter int PAGE_COUNT = 128,
   parameter int MAX_LENGTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire poc_pkg::poc_cmd_type         cmd,
   output poc_pkg::poc_status_type           status,
   input  wire logic                         req_action,
   input  wire logic [poc_pkg::PAGE_W-1:0]   req_rule_first,
   input  wire logic [poc_pkg::PAGE_W-1:0]   req_rule_second,
   input  wire logic [poc_pkg::PAGE_W-1:0]   req_page,
   input  wire logic                         req_last_in_sequence,
   output logic                              rsp_valid,
   output logic                              rsp_sequence_valid,
   output logic      [poc_pkg::PAGE_W-1:0]   rsp_middle_page,
   output logic      [poc_pkg::SUM_W-1:0]    rsp_running_sum,
   output logic                              rsp_too_long
);

   import poc_pkg::*;

   localparam int IDX_W  = $clog2(PAGE_COUNT);
   localparam int BUF_AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int CNT_W  = $clog2(MAX_LENGTH + 1);

   // Captured request.
   logic              action_ff;
   logic [PAGE_W-1:0] first_ff;
   logic [PAGE_W-1:0] second_ff;
   logic [PAGE_W-1:0] page_ff;
   logic              last_ff;

   // Sequence and global state.
   logic [PAGE_COUNT-1:0] seen_ff, seen_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  viol_ff, viol_in;
   logic                  ovf_ff, ovf_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [IDX_W-1:0]      clr_cnt_ff;
   logic                  byp_ff, byp_in;

   // Result registers.
   logic              rsp_valid_ff;
   logic              rsp_seq_valid_ff;
   logic [PAGE_W-1:0] rsp_middle_ff;
   logic [SUM_W-1:0]  rsp_sum_ff;
   logic              rsp_too_long_ff;

   // Matrix RAM.
   logic                  mat_we;
   logic [IDX_W-1:0]      mat_wr_addr;
   logic [PAGE_COUNT-1:0] mat_wr_data;
   logic [IDX_W-1:0]      mat_rd_addr;
   logic [PAGE_COUNT-1:0] mat_rd_data;

   // Sequence buffer RAM.
   logic              buf_we;
   logic [BUF_AW-1:0] buf_wr_addr;
   logic [BUF_AW-1:0] buf_rd_addr;
   logic [PAGE_W-1:0] buf_rd_data;

   logic [31:0] req_first_ext, req_page_ext;
   logic [31:0] first_ext, second_ext, page_ext;
   logic [IDX_W-1:0] first_idx, second_idx, page_idx;
   logic first_ok, second_ok, page_ok;
   logic is_page, room, hit;
   logic [CNT_W-1:0] count_new;
   logic [CNT_W-1:0] mid_full;
   logic [PAGE_W-1:0] middle;
   logic [SUM_W:0] sum_wide;

   assign req_first_ext = 32'(req_rule_first);
   assign req_page_ext  = 32'(req_page);
   assign first_ext     = 32'(first_ff);
   assign second_ext    = 32'(second_ff);
   assign page_ext      = 32'(page_ff);
   assign first_idx     = first_ext[IDX_W-1:0];
   assign second_idx    = second_ext[IDX_W-1:0];
   assign page_idx      = page_ext[IDX_W-1:0];
   assign first_ok      = first_ext < 32'(PAGE_COUNT);
   assign second_ok     = second_ext < 32'(PAGE_COUNT);
   assign page_ok       = page_ext < 32'(PAGE_COUNT);
   assign is_page       = (action_ff == ACTION_PAGE);

   // The row address is taken straight from the request in the accept cycle so
   // that the row is ready in the execute cycle.
   assign mat_rd_addr = (req_action == ACTION_PAGE) ? req_page_ext[IDX_W-1:0]
                                                    : req_first_ext[IDX_W-1:0];

   always_comb begin
      mat_we      = 1'b0;
      mat_wr_addr = first_idx;
      mat_wr_data = mat_rd_data | (PAGE_COUNT'(1) << second_idx);
      if (cmd.clear_write) begin
         mat_we      = 1'b1;
         mat_wr_addr = clr_cnt_ff;
         mat_wr_data = '0;
      end else if (cmd.exec && !is_page && first_ok && second_ok) begin
         mat_we = 1'b1;
      end
   end

   poc_ram #(
      .WIDTH (PAGE_COUNT),
      .DEPTH (PAGE_COUNT)
   ) u_matrix (
      .clock   (clock),
      .we      (mat_we),
      .wr_addr (mat_wr_addr),
      .wr_data (mat_wr_data),
      .rd_addr (mat_rd_addr),
      .rd_data (mat_rd_data)
   );

   assign hit       = |(mat_rd_data & seen_ff);
   assign room      = count_ff < CNT_W'(MAX_LENGTH);
   assign count_new = room ? count_ff + CNT_W'(1) : count_ff;
   assign mid_full  = count_new >> 1;

   assign buf_we      = cmd.exec && is_page && room;
   assign buf_wr_addr = count_ff[BUF_AW-1:0];
   assign buf_rd_addr = mid_full[BUF_AW-1:0];

   poc_ram #(
      .WIDTH (PAGE_W),
      .DEPTH (MAX_LENGTH)
   ) u_seq_buf (
      .clock   (clock),
      .we      (buf_we),
      .wr_addr (buf_wr_addr),
      .wr_data (page_ff),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   // The middle element may be the one written in the same cycle.
   assign byp_in = buf_we && (buf_rd_addr == buf_wr_addr);

   assign middle   = ovf_ff ? '0 : (byp_ff ? page_ff : buf_rd_data);
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(middle);

   always_comb begin
      seen_in  = seen_ff;
      count_in = count_ff;
      viol_in  = viol_ff;
      ovf_in   = ovf_ff;
      sum_in   = sum_ff;
      if (cmd.exec && is_page) begin
         if (page_ok) begin
            viol_in = viol_ff | hit;
            seen_in = seen_ff | (PAGE_COUNT'(1) << page_idx);
         end
         count_in = count_new;
         ovf_in   = ovf_ff | !room;
      end
      if (cmd.finish) begin
         seen_in  = '0;
         count_in = '0;
         viol_in  = 1'b0;
         ovf_in   = 1'b0;
         if (!ovf_ff && !viol_ff) begin
            sum_in = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         count_ff     <= '0;
         viol_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         sum_ff       <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         count_ff     <= count_in;
         viol_ff      <= viol_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= cmd.finish;
         if (cmd.clear_write) begin
            clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         first_ff  <= req_rule_first;
         second_ff <= req_rule_second;
         page_ff   <= req_page;
         last_ff   <= req_last_in_sequence;
      end
      if (cmd.exec) begin
         byp_ff <= byp_in;
      end
      if (cmd.finish) begin
         rsp_seq_valid_ff <= !viol_ff;
         rsp_middle_ff    <= middle;
         rsp_sum_ff       <= sum_in;
         rsp_too_long_ff  <= ovf_ff;
      end
   end

   assign status.clear_last   = (clr_cnt_ff == IDX_W'(PAGE_COUNT - 1));
   assign status.needs_finish = is_page && last_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sequence_valid = rsp_seq_valid_ff;
   assign rsp_middle_page    = rsp_middle_ff;
   assign rsp_running_sum    = rsp_sum_ff;
   assign rsp_too_long       = rsp_too_long_ff;

endmodule

`default_nettype wire

// ----- src/precedence_order_checker_core.sv -----
// Precedence order checker: rule items and last-free page items are accepted,
// then run an execute step on the registered matrix row; a last page adds a
// finish step, and its result shows in the cycle after that, with rsp_valid.
// The matrix RAM's registered read sets the execute step.
// Reset is synchronous; after it the matrix is cleared one row a cycle, so busy
// stays high until every one of the PAGE_COUNT rows is clear and the first transfer can be taken.
`default_nettype none

module precedence_order_checker_core #(
   parameter int PAGE_COUNT = 128,
   parameter int MAX_LENGTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_action,
   input  wire logic [poc_pkg::PAGE_W-1:0] req_rule_first,
   input  wire logic [poc_pkg::PAGE_W-1:0] req_rule_second,
   input  wire logic [poc_pkg::PAGE_W-1:0] req_page,
   input  wire logic                       req_last_in_sequence,
   output logic                            rsp_valid,
   output logic                            rsp_sequence_valid,
   output logic      [poc_pkg::PAGE_W-1:0] rsp_middle_page,
   output logic      [poc_pkg::SUM_W-1:0]  rsp_running_sum,
   output logic                            rsp_too_long
);

   import poc_pkg::*;

   // The controller only sequences the work: it tells the datapath when to
   // capture a request transfer, when to sweep the matrix clear, when to run
   // the check or rule update, and when to build a result.
   poc_cmd_type    cmd;
   poc_status_type status;

   poc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // The datapath holds the precedence matrix, the seen-page bitmap, the
   // element buffer used for the middle pick, and the saturating sum.
   poc_dp #(
      .PAGE_COUNT (PAGE_COUNT),
      .MAX_LENGTH (MAX_LENGTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_action           (req_action),
      .req_rule_first       (req_rule_first),
      .req_rule_second      (req_rule_second),
      .req_page             (req_page),
      .req_last_in_sequence (req_last_in_sequence),
      .rsp_valid            (rsp_valid),
      .rsp_sequence_valid   (rsp_sequence_valid),
      .rsp_middle_page      (rsp_middle_page),
      .rsp_running_sum      (rsp_running_sum),
      .rsp_too_long         (rsp_too_long)
   );

   // A result only ever follows a finish step, which runs while busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result transfer without preceding work");

   // An accepted transfer always spends the next cycle executing, never
   // presenting a result.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted transfer did not enter execution");

   // An overlong sequence reports no middle page.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_long) |-> (rsp_middle_page == '0))
      else $error("middle page reported for overlong sequence");

   // The running sum never drops from one result to the next.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.finish) |=> (rsp_running_sum >= $past(u_dp.sum_ff)))
      else $error("running sum decreased");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for precedence_order_checker_core.
// Depends on poc_pkg and the core; drives rule and page transfers, predicts each
// sequence verdict internally and checks every rsp_valid strobe against it.

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import poc_pkg::*;

   localparam int PAGE_COUNT  = 128;
   localparam int MAX_LENGTH  = 32;
   localparam int RANDOM_ITEMS = 1600;
   // About 1650 items with their idle gaps stay well under the limit even when
   // every gap is a long one; the limit leaves several times the worst run as
   // headroom.
   localparam int CYCLE_LIMIT = 1_000_000;

   // One sequence verdict, as the block reports it on the rsp_ ports.
   typedef struct {
      bit                in_order;
      bit [PAGE_W-1:0]   middle;
      bit [SUM_W-1:0]    total;
      bit                too_long;
   } verdict_type;

   // Tracks the precedence rules and the open sequence, and keeps the verdicts
   // that are still owed by the block in the order they were earned.
   class verdict_book_type;
      bit [PAGE_COUNT-1:0] must_precede [PAGE_COUNT];
      bit [PAGE_COUNT-1:0] seen;
      bit [PAGE_W-1:0]     kept_pages [MAX_LENGTH];
      int unsigned         kept_count;
      bit                  broke_order;
      bit                  overran;
      bit [SUM_W-1:0]      middle_total;
      verdict_type         expected_verdicts [$];
      int unsigned         errors;

      function void record_transfer(bit action, bit [PAGE_W-1:0] first,
                                    bit [PAGE_W-1:0] second, bit [PAGE_W-1:0] page,
                                    bit last);
         verdict_type v;
         int unsigned sum_wide;
         if (action == ACTION_RULE) begin
            if (first < PAGE_COUNT && second < PAGE_COUNT)
               must_precede[first][second] = 1'b1;
            return;
         end
         if (page < PAGE_COUNT) begin
            if ((must_precede[page] & seen) != '0)
               broke_order = 1'b1;
            seen[page] = 1'b1;
         end
         if (kept_count < MAX_LENGTH) begin
            kept_pages[kept_count] = page;
            kept_count++;
         end else begin
            overran = 1'b1;
         end
         if (!last)
            return;
         v.middle = '0;
         if (!overran) begin
            v.middle = kept_pages[kept_count / 2];
            if (!broke_order) begin
               sum_wide = middle_total + v.middle;
               middle_total = (sum_wide > SUM_MAX) ? SUM_MAX : sum_wide[SUM_W-1:0];
            end
         end
         v.in_order = !broke_order;
         v.total    = middle_total;
         v.too_long = overran;
         expected_verdicts = {expected_verdicts, v};
         seen        = '0;
         kept_count  = 0;
         broke_order = 1'b0;
         overran     = 1'b0;
      endfunction

      function void flag(string what, logic [31:0] want, logic [31:0] got);
         errors++;
         $display("%0t: %s expected %0d, actual %0d", $realtime, what, want, got);
      endfunction

      function void compare_verdict(logic in_order, logic [PAGE_W-1:0] middle,
                                    logic [SUM_W-1:0] total, logic too_long);
         verdict_type v;
         if (expected_verdicts.size() == 0) begin
            flag("unexpected result, pending count", 0, 1);
            return;
         end
         v = expected_verdicts.pop_front();
         if (in_order !== v.in_order) flag("sequence_valid", v.in_order, in_order);
         if (middle !== v.middle)     flag("middle_page", v.middle, middle);
         if (total !== v.total)       flag("running_sum", v.total, total);
         if (too_long !== v.too_long) flag("too_long", v.too_long, too_long);
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_action;
   logic [PAGE_W-1:0]   req_rule_first;
   logic [PAGE_W-1:0]   req_rule_second;
   logic [PAGE_W-1:0]   req_page;
   logic                req_last_in_sequence;
   logic                rsp_valid;
   logic                rsp_sequence_valid;
   logic [PAGE_W-1:0]   rsp_middle_page;
   logic [SUM_W-1:0]    rsp_running_sum;
   logic                rsp_too_long;

   verdict_book_type ledger;
   bit          no_idle;   // set for stretches in which start is never dropped
   int unsigned cycle_count;

   precedence_order_checker_core #(
      .PAGE_COUNT(PAGE_COUNT),
      .MAX_LENGTH(MAX_LENGTH)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_action           (req_action),
      .req_rule_first       (req_rule_first),
      .req_rule_second      (req_rule_second),
      .req_page             (req_page),
      .req_last_in_sequence (req_last_in_sequence),
      .rsp_valid            (rsp_valid),
      .rsp_sequence_valid   (rsp_sequence_valid),
      .rsp_middle_page      (rsp_middle_page),
      .rsp_running_sum      (rsp_running_sum),
      .rsp_too_long         (rsp_too_long)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: a run that has not finished by the limit is a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // Results cannot be held off, so every strobe is checked at the edge that
   // ends its cycle. Outputs are read before the edge's updates land.
   always @(posedge clock) begin
      if (reset == 1'b0 && rsp_valid === 1'b1)
         ledger.compare_verdict(rsp_sequence_valid, rsp_middle_page, rsp_running_sum,
                                rsp_too_long);
   end

   // Idle time after a transfer: mostly none or short, now and then long.
   function automatic int unsigned idle_cycles();
      int unsigned roll;
      if (no_idle)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Presents one item and holds it until the block takes it. When no idle time
   // follows, start stays high so the next call can present its item at once;
   // start is only lowered when a gap follows, so it never gets two updates in
   // one time step.
   task automatic transfer_item(bit action, bit [PAGE_W-1:0] first,
                                bit [PAGE_W-1:0] second, bit [PAGE_W-1:0] page,
                                bit last);
      int unsigned gap;
      req_action           <= action;
      req_rule_first       <= first;
      req_rule_second      <= second;
      req_page             <= page;
      req_last_in_sequence <= last;
      start                <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      ledger.record_transfer(action, first, second, page, last);
      gap = idle_cycles();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Most rules agree with ascending page order, so sorted sequences usually
   // pass; the rest are arbitrary, self rules and reversed pairs included.
   task automatic send_random_rule();
      bit [PAGE_W-1:0] first;
      bit [PAGE_W-1:0] second;
      if ($urandom_range(0, 99) < 85) begin
         first  = PAGE_W'($urandom_range(0, 126));
         second = PAGE_W'($urandom_range(first + 1, 127));
      end else begin
         first  = PAGE_W'($urandom_range(0, 127));
         second = PAGE_W'($urandom_range(0, 127));
      end
      transfer_item(ACTION_RULE, first, second, PAGE_W'($urandom_range(0, 127)),
                    1'($urandom_range(0, 1)));
   endtask

   initial begin
      bit [PAGE_W-1:0] pages [$];
      int unsigned     items;
      int unsigned     span;
      int unsigned     roll;

      ledger               = new;
      no_idle              = 1'b0;
      reset                <= 1'b1;
      start                <= 1'b0;
      req_action           <= ACTION_RULE;
      req_rule_first       <= '0;
      req_rule_second      <= '0;
      req_page             <= '0;
      req_last_in_sequence <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The block clears its matrix after reset, so the first
      // transfer simply waits on busy.
      transfer_item(ACTION_RULE, 7'd0, 7'd127, 7'd127, 1'b1);
      transfer_item(ACTION_RULE, 7'd127, 7'd0, 7'd0, 1'b0);
      transfer_item(ACTION_RULE, 7'd5, 7'd5, 7'd0, 1'b1);
      transfer_item(ACTION_RULE, 7'd10, 7'd20, 7'd127, 1'b0);
      // Single-page sequences at both ends of the page range.
      transfer_item(ACTION_PAGE, 7'd127, 7'd127, 7'd0, 1'b1);
      transfer_item(ACTION_PAGE, 7'd0, 7'd0, 7'd127, 1'b1);
      // Wrong order, then right order, for the rule that 10 precedes 20.
      transfer_item(ACTION_PAGE, 7'd0, 7'd0, 7'd20, 1'b0);
      transfer_item(ACTION_PAGE, 7'd0, 7'd0, 7'd10, 1'b1);
      transfer_item(ACTION_PAGE, 7'd0, 7'd0, 7'd10, 1'b0);
      transfer_item(ACTION_PAGE, 7'd0, 7'd0, 7'd20, 1'b1);
      // A repeated page fails only when the page has a rule against itself.
      transfer_item(ACTION_PAGE, 7'd0, 7'd0, 7'd5, 1'b0);
      transfer_item(ACTION_PAGE, 7'd0, 7'd0, 7'd5, 1'b1);
      transfer_item(ACTION_PAGE, 7'd0, 7'd0, 7'd3, 1'b0);
      transfer_item(ACTION_PAGE, 7'd0, 7'd0, 7'd3, 1'b1);
      // A rule arriving mid-sequence leaves the open sequence untouched, and its
      // page and last fields are ignored.
      transfer_item(ACTION_PAGE, 7'd0, 7'd0, 7'd20, 1'b0);
      transfer_item(ACTION_RULE, 7'd30, 7'd40, 7'd10, 1'b1);
      transfer_item(ACTION_PAGE, 7'd0, 7'd0, 7'd10, 1'b1);
      // One element past the buffer; the page after the buffer is full is
      // still checked, so the self rule on 5 makes this one invalid too.
      for (int i = 0; i < MAX_LENGTH; i++)
         transfer_item(ACTION_PAGE, 7'd0, 7'd0, i[PAGE_W-1:0], 1'b0);
      transfer_item(ACTION_PAGE, 7'd0, 7'd0, 7'd5, 1'b1);

      // Random part: mostly complete sequences with random content, some of
      // them sorted so that they stand a chance of passing the rules, with
      // rules mixed in both between and inside sequences.
      items = 0;
      while (items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0)
            no_idle = !no_idle;
         if ($urandom_range(0, 99) < 30) begin
            send_random_rule();
            items++;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 88)      span = $urandom_range(1, 8);
            else if (roll < 96) span = $urandom_range(9, 29);
            else                span = $urandom_range(30, 36);
            pages.delete();
            for (int i = 0; i < span; i++)
               pages = {pages, PAGE_W'($urandom_range(0, 127))};
            if ($urandom_range(0, 1) == 1)
               pages.sort();
            for (int i = 0; i < span; i++) begin
               if ($urandom_range(0, 99) < 5) begin
                  send_random_rule();
                  items++;
               end
               transfer_item(ACTION_PAGE, PAGE_W'($urandom_range(0, 127)),
                             PAGE_W'($urandom_range(0, 127)), pages[i], i == span - 1);
               items++;
            end
         end
      end
      start <= 1'b0;

      // Drain: the watchdog covers a verdict that never shows up.
      while (ledger.expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (ledger.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
